### sv/bmprle_pkg.sv
// ----------------------------------------------------------------------------
// BMP RLE decoder package
// Result kinds, escape codes, configuration indices and the span record shared by the decoder and its checker.
// ----------------------------------------------------------------------------
package bmprle_pkg;

    typedef enum logic [1:0] {
        KIND_SPAN  = 2'd0,
        KIND_FILL  = 2'd1,
        KIND_END   = 2'd2,
        KIND_EARLY = 2'd3
    } t_kind;

    localparam logic [7:0] ESC_EOL   = 8'd0;
    localparam logic [7:0] ESC_EOB   = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    localparam logic CFG_NIBBLE_MODE = 1'b0;
    localparam logic CFG_ROW_WIDTH   = 1'b1;

    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] x_start;
        logic [15:0] y_start;
        logic [7:0]  length;
        logic [7:0]  index_even;
        logic [7:0]  index_odd;
    } t_span;

endpackage

### sv/bmp_rle_span_decoder.sv
// Queueing: an accepted byte's results are registered into the result queue
// behind any older ones. Throughput: one byte per cycle; a byte may give up to
// three results, which leave the four-entry result queue at one per cycle while
// the receiver is ready. A byte is taken whenever at most one result is queued.
// Reset: synchronous, active low; clears parse state, cursor and the result
// queue, and sets RLE8 mode with a row width of one.
// ----------------------------------------------------------------------------
// BMP RLE8/RLE4 span decoder
// Parses the compressed byte stream in one pass per byte and emits spans of
// palette indices, whole-row fills, end of bitmap and early-end markers.
// ----------------------------------------------------------------------------
module bmp_rle_span_decoder #(
    parameter int COORD_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [15:0]          i_cfg_data,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bmprle_pkg::t_kind    o_kind,
    output logic [15:0]          o_x_start,
    output logic [15:0]          o_y_start,
    output logic [7:0]           o_length,
    output logic [7:0]           o_index_even,
    output logic [7:0]           o_index_odd
);
    import bmprle_pkg::*;

    localparam int WB = (COORD_BITS > 16) ? COORD_BITS : 16;
    localparam int QA = $clog2(QUEUE_DEPTH);
    localparam int QC = $clog2(QUEUE_DEPTH + 1);
    localparam logic [COORD_BITS-1:0] CMAX = {COORD_BITS{1'b1}};

    typedef enum logic [2:0] {
        PH_COUNT = 3'd0,
        PH_VALUE = 3'd1,
        PH_DX    = 3'd2,
        PH_DY    = 3'd3,
        PH_ABS   = 3'd4,
        PH_PAD   = 3'd5
    } t_phase;

    function automatic logic [COORD_BITS-1:0] sat_add(
        input logic [COORD_BITS-1:0] a,
        input logic [7:0]            b
    );
        logic [COORD_BITS:0] s;
        s = {1'b0, a} + (COORD_BITS+1)'(b);
        return s[COORD_BITS] ? CMAX : s[COORD_BITS-1:0];
    endfunction

    function automatic t_span mk(
        input t_kind                 kind,
        input logic [COORD_BITS-1:0] x,
        input logic [COORD_BITS-1:0] y,
        input logic [7:0]            len,
        input logic [7:0]            ie,
        input logic [7:0]            io
    );
        logic [WB-1:0] xe;
        logic [WB-1:0] ye;
        t_span         s;
        xe = WB'(x);
        ye = WB'(y);
        s.kind       = kind;
        s.x_start    = xe[15:0];
        s.y_start    = ye[15:0];
        s.length     = len;
        s.index_even = ie;
        s.index_odd  = io;
        return s;
    endfunction

    // configuration
    logic                  r_nibble_mode;
    logic [15:0]           r_row_width;

    // parse state
    t_phase                r_phase,       n_phase;
    logic [7:0]            r_run_length,  n_run_length;
    logic [7:0]            r_pixels_left, n_pixels_left;
    logic                  r_pad_pending, n_pad_pending;
    logic [7:0]            r_delta_dx,    n_delta_dx;
    logic [COORD_BITS-1:0] r_cursor_x,    n_cursor_x;
    logic [COORD_BITS-1:0] r_cursor_y,    n_cursor_y;
    logic                  r_finished,    n_finished;

    // result queue
    t_span                 r_queue [QUEUE_DEPTH];
    logic [QA-1:0]         r_head, r_tail;
    logic [QC-1:0]         r_count, n_count;

    t_span                 res [MAX_RESULTS];
    logic [1:0]            res_cnt;
    logic [1:0]            push_cnt;
    logic                  in_acc, pop;
    logic [3:0]            hi, lo;
    logic [7:0]            abs_len;
    logic [8:0]            b_inc;
    logic [WB-1:0]         rw_ext;
    logic [COORD_BITS-1:0] rw_clamp;

    assign o_in_ready  = (r_count <= QC'(1));
    assign in_acc      = i_in_valid & o_in_ready;
    assign o_out_valid = (r_count != '0);
    assign pop         = o_out_valid & i_out_ready;
    assign push_cnt    = in_acc ? res_cnt : 2'd0;
    assign n_count     = r_count + QC'(push_cnt) - QC'(pop);

    assign o_kind       = r_queue[r_head].kind;
    assign o_x_start    = r_queue[r_head].x_start;
    assign o_y_start    = r_queue[r_head].y_start;
    assign o_length     = r_queue[r_head].length;
    assign o_index_even = r_queue[r_head].index_even;
    assign o_index_odd  = r_queue[r_head].index_odd;

    assign hi       = i_data_byte[7:4];
    assign lo       = i_data_byte[3:0];
    assign b_inc    = {1'b0, i_data_byte} + 9'd1;
    assign rw_ext   = WB'(r_row_width);
    assign rw_clamp = (rw_ext > WB'(CMAX)) ? CMAX : COORD_BITS'(rw_ext);

    always_comb begin
        if (r_nibble_mode) begin
            abs_len = (r_pixels_left >= 8'd2) ? 8'd2 : r_pixels_left;
        end else begin
            abs_len = (r_pixels_left != 8'd0) ? 8'd1 : 8'd0;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_run_length  = r_run_length;
        n_pixels_left = r_pixels_left;
        n_pad_pending = r_pad_pending;
        n_delta_dx    = r_delta_dx;
        n_cursor_x    = r_cursor_x;
        n_cursor_y    = r_cursor_y;
        n_finished    = r_finished;
        res_cnt       = 2'd0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            res[k] = '0;
        end

        if (!r_finished) begin
            unique case (r_phase)
                PH_VALUE: begin
                    if (r_run_length != 8'd0) begin
                        res[res_cnt] = r_nibble_mode
                            ? mk(KIND_SPAN, r_cursor_x, r_cursor_y, r_run_length,
                                 {4'h0, hi}, {4'h0, lo})
                            : mk(KIND_SPAN, r_cursor_x, r_cursor_y, r_run_length,
                                 i_data_byte, i_data_byte);
                        res_cnt    = res_cnt + 2'd1;
                        n_cursor_x = sat_add(r_cursor_x, r_run_length);
                        n_phase    = PH_COUNT;
                    end else begin
                        unique case (i_data_byte)
                            ESC_EOL: begin
                                n_cursor_x = '0;
                                n_cursor_y = sat_add(r_cursor_y, 8'd1);
                                n_phase    = PH_COUNT;
                            end
                            ESC_EOB: begin
                                n_finished   = 1'b1;
                                res[res_cnt] = mk(KIND_END, r_cursor_x, r_cursor_y,
                                                  8'd0, 8'd0, 8'd0);
                                res_cnt      = res_cnt + 2'd1;
                                n_phase      = PH_COUNT;
                            end
                            ESC_DELTA: begin
                                n_phase = PH_DX;
                            end
                            default: begin
                                n_pixels_left = i_data_byte;
                                n_pad_pending = r_nibble_mode ? b_inc[1] : i_data_byte[0];
                                n_phase       = PH_ABS;
                            end
                        endcase
                    end
                end
                PH_DX: begin
                    n_delta_dx = i_data_byte;
                    n_phase    = PH_DY;
                end
                PH_DY: begin
                    if (r_delta_dx != 8'd0) begin
                        res[res_cnt] = mk(KIND_SPAN, r_cursor_x, r_cursor_y, r_delta_dx,
                                          8'd0, 8'd0);
                        res_cnt      = res_cnt + 2'd1;
                        n_cursor_x   = sat_add(r_cursor_x, r_delta_dx);
                    end
                    if (i_data_byte != 8'd0) begin
                        res[res_cnt] = mk(KIND_FILL, '0, r_cursor_y, i_data_byte,
                                          8'd0, 8'd0);
                        res_cnt      = res_cnt + 2'd1;
                        n_cursor_y   = sat_add(r_cursor_y, i_data_byte);
                        n_cursor_x   = rw_clamp;
                    end
                    n_phase = PH_COUNT;
                end
                PH_ABS: begin
                    res[res_cnt] = r_nibble_mode
                        ? mk(KIND_SPAN, r_cursor_x, r_cursor_y, abs_len,
                             {4'h0, hi}, {4'h0, lo})
                        : mk(KIND_SPAN, r_cursor_x, r_cursor_y, abs_len,
                             i_data_byte, i_data_byte);
                    res_cnt       = res_cnt + 2'd1;
                    n_cursor_x    = sat_add(r_cursor_x, abs_len);
                    n_pixels_left = r_pixels_left - abs_len;
                    if (n_pixels_left == 8'd0) begin
                        n_phase = r_pad_pending ? PH_PAD : PH_COUNT;
                    end
                end
                PH_PAD: begin
                    n_pad_pending = 1'b0;
                    n_phase       = PH_COUNT;
                end
                default: begin
                    n_run_length = i_data_byte;
                    n_phase      = PH_VALUE;
                end
            endcase

            if (i_last && !n_finished) begin
                res[res_cnt] = mk(KIND_EARLY, n_cursor_x, n_cursor_y, 8'd0, 8'd0, 8'd0);
                res_cnt      = res_cnt + 2'd1;
                n_finished   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nibble_mode <= 1'b0;
            r_row_width   <= 16'd1;
            r_phase       <= PH_COUNT;
            r_run_length  <= '0;
            r_pixels_left <= '0;
            r_pad_pending <= 1'b0;
            r_delta_dx    <= '0;
            r_cursor_x    <= '0;
            r_cursor_y    <= '0;
            r_finished    <= 1'b0;
            r_head        <= '0;
            r_tail        <= '0;
            r_count       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_NIBBLE_MODE: r_nibble_mode <= i_cfg_data[0];
                    CFG_ROW_WIDTH:   r_row_width   <= i_cfg_data;
                    default:         r_row_width   <= r_row_width;
                endcase
            end
            if (in_acc) begin
                r_phase       <= n_phase;
                r_run_length  <= n_run_length;
                r_pixels_left <= n_pixels_left;
                r_pad_pending <= n_pad_pending;
                r_delta_dx    <= n_delta_dx;
                r_cursor_x    <= n_cursor_x;
                r_cursor_y    <= n_cursor_y;
                r_finished    <= n_finished;
            end
            if (pop) begin
                r_head <= r_head + QA'(1);
            end
            r_tail  <= r_tail + QA'(push_cnt);
            r_count <= n_count;
        end
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (2'(k) < push_cnt) begin
                r_queue[r_tail + QA'(k)] <= res[k];
            end
        end
    end

endmodule

### verif/bmp_rle_span_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BMP RLE span decoder checker
// Watches the byte and span channels of the decoder, keeps its own model of
// the parser, cursor and configuration, and compares every span transaction
// against the oldest predicted one. Reports failures and outstanding spans.
// ----------------------------------------------------------------------------
module bmp_rle_span_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [15:0]          i_cfg_data,

    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last,

    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  bmprle_pkg::t_kind    i_kind,
    input  logic [15:0]          i_x_start,
    input  logic [15:0]          i_y_start,
    input  logic [7:0]           i_length,
    input  logic [7:0]           i_index_even,
    input  logic [7:0]           i_index_odd,

    output int                   o_errors,
    output int                   o_pending,
    output logic                 o_at_count
);
    import bmprle_pkg::*;

    localparam logic [15:0] COORD_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_COUNT,
        ST_VALUE,
        ST_DX,
        ST_DY,
        ST_ABS,
        ST_PAD
    } t_parse;

    t_parse      parse_st;
    logic        nibble;
    logic [15:0] row_width;
    logic [7:0]  run_len;
    logic [7:0]  pix_left;
    logic        pad_due;
    logic [7:0]  skip_dx;
    logic [15:0] cur_x;
    logic [15:0] cur_y;
    logic        finished;
    int          err_cnt;
    t_span       expected_spans[$];

    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [7:0] inc);
        logic [16:0] s;
        s = {1'b0, a} + {9'd0, inc};
        return (s > {1'b0, COORD_MAX}) ? COORD_MAX : s[15:0];
    endfunction

    task automatic queue_span(input t_kind k, input logic [15:0] x, input logic [15:0] y,
                              input logic [7:0] len, input logic [7:0] ie,
                              input logic [7:0] io);
        t_span s;
        s.kind       = k;
        s.x_start    = x;
        s.y_start    = y;
        s.length     = len;
        s.index_even = ie;
        s.index_odd  = io;
        expected_spans.push_back(s);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic lst);
        logic [8:0] abs_bytes;
        logic [7:0] step;
        if (finished) begin
            return;
        end
        case (parse_st)
            ST_VALUE: begin
                if (run_len != 8'd0) begin
                    if (nibble) begin
                        queue_span(KIND_SPAN, cur_x, cur_y, run_len,
                                   {4'd0, b[7:4]}, {4'd0, b[3:0]});
                    end else begin
                        queue_span(KIND_SPAN, cur_x, cur_y, run_len, b, b);
                    end
                    cur_x    = sat_add(cur_x, run_len);
                    parse_st = ST_COUNT;
                end else if (b == ESC_EOL) begin
                    cur_x    = 16'd0;
                    cur_y    = sat_add(cur_y, 8'd1);
                    parse_st = ST_COUNT;
                end else if (b == ESC_EOB) begin
                    finished = 1'b1;
                    queue_span(KIND_END, cur_x, cur_y, 8'd0, 8'd0, 8'd0);
                    parse_st = ST_COUNT;
                end else if (b == ESC_DELTA) begin
                    parse_st = ST_DX;
                end else begin
                    abs_bytes = nibble ? (({1'b0, b} + 9'd1) >> 1) : {1'b0, b};
                    pix_left  = b;
                    pad_due   = abs_bytes[0];
                    parse_st  = ST_ABS;
                end
            end
            ST_DX: begin
                skip_dx  = b;
                parse_st = ST_DY;
            end
            ST_DY: begin
                if (skip_dx != 8'd0) begin
                    queue_span(KIND_SPAN, cur_x, cur_y, skip_dx, 8'd0, 8'd0);
                    cur_x = sat_add(cur_x, skip_dx);
                end
                if (b != 8'd0) begin
                    queue_span(KIND_FILL, 16'd0, cur_y, b, 8'd0, 8'd0);
                    cur_y = sat_add(cur_y, b);
                    cur_x = row_width;
                end
                parse_st = ST_COUNT;
            end
            ST_ABS: begin
                if (nibble) begin
                    step = (pix_left >= 8'd2) ? 8'd2 : pix_left;
                    queue_span(KIND_SPAN, cur_x, cur_y, step, {4'd0, b[7:4]}, {4'd0, b[3:0]});
                end else begin
                    step = (pix_left != 8'd0) ? 8'd1 : 8'd0;
                    queue_span(KIND_SPAN, cur_x, cur_y, step, b, b);
                end
                cur_x    = sat_add(cur_x, step);
                pix_left = pix_left - step;
                if (pix_left == 8'd0) begin
                    parse_st = pad_due ? ST_PAD : ST_COUNT;
                end
            end
            ST_PAD: begin
                pad_due  = 1'b0;
                parse_st = ST_COUNT;
            end
            default: begin
                run_len  = b;
                parse_st = ST_VALUE;
            end
        endcase
        if (lst && !finished) begin
            queue_span(KIND_EARLY, cur_x, cur_y, 8'd0, 8'd0, 8'd0);
            finished = 1'b1;
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            err_cnt++;
        end
    endtask

    task automatic check_result();
        t_span want;
        if (expected_spans.size() == 0) begin
            $display("%0t: unexpected span: kind %0d x %0d y %0d length %0d",
                     $time, i_kind, i_x_start, i_y_start, i_length);
            err_cnt++;
        end else begin
            want = expected_spans.pop_front();
            compare_field("kind", 16'(want.kind), 16'(i_kind));
            compare_field("x_start", want.x_start, i_x_start);
            compare_field("y_start", want.y_start, i_y_start);
            compare_field("length", 16'(want.length), 16'(i_length));
            compare_field("index_even", 16'(want.index_even), 16'(i_index_even));
            compare_field("index_odd", 16'(want.index_odd), 16'(i_index_odd));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_st  = ST_COUNT;
            nibble    = 1'b0;
            row_width = 16'd1;
            run_len   = 8'd0;
            pix_left  = 8'd0;
            pad_due   = 1'b0;
            skip_dx   = 8'd0;
            cur_x     = 16'd0;
            cur_y     = 16'd0;
            finished  = 1'b0;
            expected_spans.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NIBBLE_MODE: nibble = i_cfg_data[0];
                    CFG_ROW_WIDTH:   row_width = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_data_byte, i_last);
            end
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
        end
        o_errors   <= err_cnt;
        o_pending  <= expected_spans.size();
        o_at_count <= (parse_st == ST_COUNT);
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// BMP RLE span decoder testbench
// Drives compressed RLE8/RLE4 byte streams into the decoder under several
// configurations and handshake idling patterns; a checker beside the decoder
// predicts and compares every span transaction.
// ----------------------------------------------------------------------------
module testbench;
    import bmprle_pkg::*;

    localparam logic [7:0] ESCAPE = 8'd0;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    t_kind       out_kind;
    logic [15:0] x_start;
    logic [15:0] y_start;
    logic [7:0]  span_len;
    logic [7:0]  index_even;
    logic [7:0]  index_odd;

    int          chk_errors;
    int          chk_pending;
    logic        at_count;

    int          send_idle_pct = 15;
    int          recv_idle_pct = 69;
    int          hold_requests = 0;
    int          bytes_sent = 0;
    logic        nibble_now = 1'b0;
    logic [7:0]  prev_byte = 8'hFF;

    bmp_rle_span_decoder i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_data_byte  (data_byte),
        .i_last       (last),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_kind       (out_kind),
        .o_x_start    (x_start),
        .o_y_start    (y_start),
        .o_length     (span_len),
        .o_index_even (index_even),
        .o_index_odd  (index_odd)
    );

    bmp_rle_span_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_data_byte  (data_byte),
        .i_last       (last),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_kind       (out_kind),
        .i_x_start    (x_start),
        .i_y_start    (y_start),
        .i_length     (span_len),
        .i_index_even (index_even),
        .i_index_odd  (index_odd),
        .o_errors     (chk_errors),
        .o_pending    (chk_pending),
        .o_at_count   (at_count)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // output side: random stalls, plus a long hold-off on request
    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // a zero followed by a one would end the bitmap; only the end of the run may do that
    task automatic send_byte(input logic [7:0] b, input logic lst, input logic raw);
        if (!raw && prev_byte == ESCAPE && b == ESC_EOB) begin
            b = b + 8'd1;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last      <= lst;
        prev_byte = b;
        bytes_sent++;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (chk_pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_config(input logic nib, input logic [15:0] width);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NIBBLE_MODE;
        cfg_data  <= {15'd0, nib};
        @(negedge clk);
        cfg_index <= CFG_ROW_WIDTH;
        cfg_data  <= width;
        @(negedge clk);
        cfg_we    <= 1'b0;
        nibble_now = nib;
    endtask

    task automatic enc_run(input logic [7:0] count, input logic [7:0] value);
        send_byte(count, 1'b0, 1'b0);
        send_byte(value, 1'b0, 1'b0);
    endtask

    task automatic end_of_line();
        send_byte(ESCAPE, 1'b0, 1'b0);
        send_byte(ESC_EOL, 1'b0, 1'b0);
    endtask

    task automatic delta(input logic [7:0] dx, input logic [7:0] dy);
        send_byte(ESCAPE, 1'b0, 1'b0);
        send_byte(ESC_DELTA, 1'b0, 1'b0);
        send_byte(dx, 1'b0, 1'b0);
        send_byte(dy, 1'b0, 1'b0);
    endtask

    task automatic abs_run(input logic [7:0] n);
        logic [8:0] nb;
        nb = nibble_now ? (({1'b0, n} + 9'd1) >> 1) : {1'b0, n};
        send_byte(ESCAPE, 1'b0, 1'b0);
        send_byte(n, 1'b0, 1'b0);
        repeat (nb) send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
        if (nb[0]) begin
            send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
        end
    endtask

    task automatic random_stream(input int target);
        int stop_at;
        int pick;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                enc_run(8'($urandom_range(1, 255)), 8'($urandom_range(255)));
            end else if (pick < 47) begin
                end_of_line();
            end else if (pick < 65) begin
                delta(($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
                      ($urandom_range(9) < 4) ? 8'd0 : 8'($urandom_range(1, 255)));
            end else if (pick < 90) begin
                abs_run(($urandom_range(9) == 0) ? 8'($urandom_range(3, 255))
                                                 : 8'($urandom_range(3, 16)));
            end else begin
                // broken sequence: stray bytes, then zeros until the parser waits for a count
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
                while (!at_count) send_byte(8'd0, 1'b0, 1'b0);
            end
        end
    endtask

    initial begin
        int ending;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_NIBBLE_MODE;
        cfg_data  = 16'd0;
        in_valid  = 1'b0;
        data_byte = 8'd0;
        last      = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_config(1'b0, 16'd1);
        enc_run(8'd255, 8'hFF);
        end_of_line();
        delta(8'd0, 8'd0);
        delta(8'd255, 8'd255);
        enc_run(8'd1, 8'h00);
        drain();
        set_config(1'b1, 16'd0);
        delta(8'd0, 8'd7);
        // absolute run opened in RLE4, finished in RLE8
        send_byte(ESCAPE, 1'b0, 1'b0);
        send_byte(8'd6, 1'b0, 1'b0);
        send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
        drain();
        set_config(1'b0, 16'd0);
        repeat (5) send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
        drain();
        set_config(1'b1, 16'hFFFF);
        delta(8'd1, 8'd1);
        enc_run(8'd9, 8'h5A);

        drain();
        set_config(1'b0, 16'($urandom_range(1, 640)));
        hold_requests++;
        random_stream(60);
        drain();
        set_config(1'b1, 16'($urandom_range(1, 640)));
        random_stream(60);

        drain();
        send_idle_pct = 69;
        recv_idle_pct = 15;
        set_config(1'b1, 16'd1);
        random_stream(60);
        drain();
        set_config(1'b0, 16'hFFFF);
        random_stream(60);

        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(1'($urandom_range(1)), 16'($urandom_range(1, 65535)));
        hold_requests++;
        random_stream(120);

        enc_run(8'($urandom_range(1, 255)), 8'($urandom_range(255)));

        ending = $urandom_range(1);
        if (ending == 0) begin
            send_byte(ESCAPE, 1'b0, 1'b0);
            send_byte(ESC_EOB, 1'($urandom_range(1)), 1'b1);
        end else begin
            send_byte(8'($urandom_range(255)), 1'b1, 1'b0);
        end
        repeat (3) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);

        in_valid <= 1'b0;
        while (chk_pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
